FILE: design/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants of the nearest leader search block
// Sizes, field widths, operation and register codes, and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

    // Store sizes.
    localparam int MAX_LEADERS = 64;
    localparam int MAX_DIMS    = 128;

    // Fixed field widths of the stream items.
    localparam int LEAD_FIELD_W = 6;
    localparam int DIM_FIELD_W  = 7;
    localparam int ELEM_W       = 8;
    localparam int DIST_W       = 23;

    // Configuration register widths.
    localparam int LCOUNT_W = 7;
    localparam int DCOUNT_W = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Internal widths derived from the store sizes.
    localparam int LEAD_W     = $clog2(MAX_LEADERS);
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int LADDR_W    = LEAD_W + DIM_W;
    localparam int LSTORE_DEPTH = 1 << LADDR_W;
    localparam int SQ_W       = 2 * ELEM_W;
    localparam int ACC_RAW_W  = $clog2(MAX_DIMS * 65025 + 1);
    localparam int ACC_W      = (ACC_RAW_W > DIST_W) ? ACC_RAW_W : DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE  = 1'b1;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        OP_LEADER = 1'b0,
        OP_QUERY  = 1'b1
    } nls_op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic              rd_en;
        logic [LEAD_W-1:0] rd_lead;
        logic [DIM_W-1:0]  rd_dim;
        logic              rd_first;
        logic              rd_last;
        logic              leader_we;
        logic              query_we;
        logic              load_out;
        logic              load_special;
        logic              no_leaders;
    } nls_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic busy;
    } nls_status_t;

endpackage

`default_nettype wire

FILE: design/nls_ram.sv
// ----------------------------------------------------------------------------
// nls_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/nls_ctrl.sv
// ----------------------------------------------------------------------------
// nls_ctrl: controller of the nearest leader search
// Holds the configuration registers, handles the input handshake, sequences
// the leader and dimension counters of a search and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [nls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nls_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire nls_pkg::nls_op_t                in_op,
    input  wire logic [nls_pkg::LEAD_FIELD_W-1:0] in_lead,
    input  wire logic [nls_pkg::DIM_FIELD_W-1:0] in_dim,
    input  wire logic                            in_last,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output nls_pkg::nls_cmd_t                    cmd,
    input  wire nls_pkg::nls_status_t            status
);

    import nls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [LCOUNT_W-1:0] leader_count_reg;
    logic [DCOUNT_W-1:0] dims_reg;
    logic [LEAD_W-1:0]   lead_reg;
    logic [DIM_W-1:0]    dim_reg;
    logic                special_reg;
    logic                out_valid_reg;

    logic [LCOUNT_W-1:0] nlead;
    logic [DCOUNT_W-1:0] ndim;
    logic                accept;
    logic                start;
    logic                dim_last;
    logic                lead_last;
    logic                out_free;
    logic                lead_ok;
    logic                dim_ok;

    // Oversized register values count as the store size.
    assign nlead = (leader_count_reg > LCOUNT_W'(MAX_LEADERS)) ?
                   LCOUNT_W'(MAX_LEADERS) : leader_count_reg;
    assign ndim  = (dims_reg > DCOUNT_W'(MAX_DIMS)) ? DCOUNT_W'(MAX_DIMS) : dims_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign start     = accept && (in_op == OP_QUERY) && in_last;
    assign dim_last  = (DCOUNT_W'(dim_reg) == ndim - DCOUNT_W'(1));
    assign lead_last = (LCOUNT_W'(lead_reg) == nlead - LCOUNT_W'(1));
    assign out_free  = !out_valid_reg || out_ready;
    assign lead_ok   = (32'(in_lead) < 32'(MAX_LEADERS));
    assign dim_ok    = (32'(in_dim) < 32'(MAX_DIMS));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd              = '0;
        cmd.rd_en        = (state_reg == S_RUN);
        cmd.rd_lead      = lead_reg;
        cmd.rd_dim       = dim_reg;
        cmd.rd_first     = (dim_reg == '0);
        cmd.rd_last      = dim_last;
        cmd.leader_we    = accept && (in_op == OP_LEADER) && lead_ok && dim_ok;
        cmd.query_we     = accept && (in_op == OP_QUERY) && dim_ok;
        cmd.load_out     = (state_reg == S_FINISH) && out_free;
        cmd.load_special = special_reg;
        cmd.no_leaders   = (nlead == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            leader_count_reg <= '0;
            dims_reg         <= DCOUNT_W'(100);
            lead_reg         <= '0;
            dim_reg          <= '0;
            special_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEADER_COUNT: leader_count_reg <= cfg_data[LCOUNT_W-1:0];
                    REG_DIMS_IN_USE:  dims_reg         <= cfg_data[DCOUNT_W-1:0];
                    default:          ;
                endcase
            end

            // A result leaving in the same cycle as a new one is loaded keeps
            // the valid high; the load below sets it.
            if (out_valid_reg && out_ready && !cmd.load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        lead_reg <= '0;
                        dim_reg  <= '0;
                        if ((nlead == '0) || (ndim == '0))
                        begin
                            special_reg <= 1'b1;
                            state_reg   <= S_FINISH;
                        end
                        else
                        begin
                            special_reg <= 1'b0;
                            state_reg   <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (dim_last)
                    begin
                        dim_reg <= '0;
                        if (lead_last)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            lead_reg <= lead_reg + LEAD_W'(1);
                        end
                    end
                    else
                    begin
                        dim_reg <= dim_reg + DIM_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!status.busy)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/nls_datapath.sv
// ----------------------------------------------------------------------------
// nls_datapath: stores and distance pipeline of the nearest leader search
// Leader and query memories, a squared difference stage, one accumulator reused for
// each leader, the running minimum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire nls_pkg::nls_cmd_t                cmd,
    output nls_pkg::nls_status_t                  status,
    input  wire logic [nls_pkg::LEAD_FIELD_W-1:0] in_lead,
    input  wire logic [nls_pkg::DIM_FIELD_W-1:0]  in_dim,
    input  wire logic [nls_pkg::ELEM_W-1:0]       in_value,
    output logic [nls_pkg::LEAD_FIELD_W-1:0]      out_index,
    output logic [nls_pkg::DIST_W-1:0]            out_distance,
    output logic                                  out_no_leaders
);

    import nls_pkg::*;

    logic [ELEM_W-1:0] query_rdata;
    logic [ELEM_W-1:0] leader_rdata;

    // Stage 1: memory read data and its tags.
    logic              v1_reg;
    logic              first1_reg;
    logic              last1_reg;
    logic [LEAD_W-1:0] idx1_reg;
    // Stage 2: squared difference.
    logic              v2_reg;
    logic              first2_reg;
    logic              last2_reg;
    logic [LEAD_W-1:0] idx2_reg;
    logic [SQ_W-1:0]   sq2_reg;
    // Stage 3: distance of one leader.
    logic              v3_reg;
    logic [LEAD_W-1:0] idx3_reg;
    logic [ACC_W-1:0]  acc_reg;
    // Running minimum.
    logic [ACC_W-1:0]  best_reg;
    logic [LEAD_W-1:0] best_idx_reg;
    // Result payload.
    logic [LEAD_FIELD_W-1:0] out_index_reg;
    logic [DIST_W-1:0]       out_distance_reg;
    logic                    out_no_leaders_reg;

    logic signed [ELEM_W:0] delta;
    logic [ELEM_W-1:0]      magnitude;
    logic [ACC_W-1:0]       acc_next;
    logic [DIST_W-1:0]      best_sat;

    nls_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_DIMS)
    ) u_query_ram (
        .clk   (clk),
        .we    (cmd.query_we),
        .waddr (in_dim[DIM_W-1:0]),
        .wdata (in_value),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_dim),
        .rdata (query_rdata)
    );

    nls_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (LSTORE_DEPTH)
    ) u_leader_ram (
        .clk   (clk),
        .we    (cmd.leader_we),
        .waddr ({in_lead[LEAD_W-1:0], in_dim[DIM_W-1:0]}),
        .wdata (in_value),
        .re    (cmd.rd_en),
        .raddr ({cmd.rd_lead, cmd.rd_dim}),
        .rdata (leader_rdata)
    );

    assign delta     = $signed({query_rdata[ELEM_W-1], query_rdata}) -
                       $signed({leader_rdata[ELEM_W-1], leader_rdata});
    assign magnitude = delta[ELEM_W] ? ELEM_W'(-delta) : delta[ELEM_W-1:0];
    assign acc_next  = (first2_reg ? '0 : acc_reg) + ACC_W'(sq2_reg);
    assign best_sat  = (best_reg > ACC_W'(DIST_MAX)) ? DIST_MAX : best_reg[DIST_W-1:0];

    assign status.busy    = v1_reg || v2_reg || v3_reg;
    assign out_index      = out_index_reg;
    assign out_distance   = out_distance_reg;
    assign out_no_leaders = out_no_leaders_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && last2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.rd_first;
        last1_reg  <= cmd.rd_last;
        idx1_reg   <= cmd.rd_lead;

        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        idx2_reg   <= idx1_reg;
        sq2_reg    <= magnitude * magnitude;

        if (v2_reg)
        begin
            acc_reg  <= acc_next;
            idx3_reg <= idx2_reg;
        end

        // Leaders finish in index order, so leader zero seeds the minimum and
        // only a strictly smaller distance replaces it.
        if (v3_reg && ((idx3_reg == '0) || (acc_reg < best_reg)))
        begin
            best_reg     <= acc_reg;
            best_idx_reg <= idx3_reg;
        end

        if (cmd.load_out)
        begin
            if (cmd.load_special)
            begin
                out_index_reg      <= '0;
                out_distance_reg   <= '0;
                out_no_leaders_reg <= cmd.no_leaders;
            end
            else
            begin
                out_index_reg      <= LEAD_FIELD_W'(best_idx_reg);
                out_distance_reg   <= best_sat;
                out_no_leaders_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/nearest_leader_search.sv
// ----------------------------------------------------------------------------
// nearest_leader_search: nearest leader by squared Euclidean distance
// Keeps a table of signed 8-bit leader vectors and finds the leader nearest
// to a query vector assembled from stream items.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_axis    in         s_tvalid / s_tready  leader or query element, tlast ends a query
//  m_axis    out        m_tvalid / m_tready  nearest index, distance, no-leaders flag
//  cfg       in         cfg_we               leader_count (0), dims_in_use (1)
//
//  Leader and non-final query items are taken while idle. A final query item stalls the
//  input while the search walks leader_count * dims_in_use elements (both clamped to
//  the store sizes): one multiply-accumulate per cycle, pipeline drain and result load;
//  with no leaders or dimensions only the load follows. A result waits in the output
//  register while items are accepted, but the next result holds the input until it leaves.
//  Reset is asynchronous and active low; the stores are not cleared.
//
`default_nettype none

module nearest_leader_search (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port.
    input  wire logic                          cfg_we,
    input  wire logic [nls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nls_pkg::CFG_W-1:0]     cfg_data,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,  // leader_index, dim_index, element_value
    input  wire logic                          s_tlast,  // last_element
    input  wire logic                          s_tuser,  // op
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,  // nearest_index, nearest_distance
    output logic                               m_tuser   // no_leaders
);

    import nls_pkg::*;

    nls_cmd_t    cmd;
    nls_status_t status;

    nls_op_t                 in_op;
    logic [LEAD_FIELD_W-1:0] in_lead;
    logic [DIM_FIELD_W-1:0]  in_dim;
    logic [ELEM_W-1:0]       in_value;

    logic [LEAD_FIELD_W-1:0] out_index;
    logic [DIST_W-1:0]       out_distance;
    logic                    out_no_leaders;

    // Unpack the input item.
    assign in_op    = nls_op_t'(s_tuser);
    assign in_lead  = s_tdata[5:0];
    assign in_dim   = s_tdata[12:6];
    assign in_value = s_tdata[20:13];

    // Pack the result item.
    assign m_tdata = {3'b000, out_distance, out_index};
    assign m_tuser = out_no_leaders;

    nls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (in_op),
        .in_lead   (in_lead),
        .in_dim    (in_dim),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    nls_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_lead        (in_lead),
        .in_dim         (in_dim),
        .in_value       (in_value),
        .out_index      (out_index),
        .out_distance   (out_distance),
        .out_no_leaders (out_no_leaders)
    );

    // The input stays stalled while distances are still in the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !s_tready)
        else $error("input accepted while a search is in flight");

    // Stores are never written while the search reads them.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !(cmd.leader_we || cmd.query_we))
        else $error("store written during a search");

    // A new result is loaded only when the previous one is gone or leaving.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // A result without leaders carries index and distance zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("no-leaders result with nonzero payload");

endmodule

`default_nettype wire

FILE: bench/nearest_leader_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_leader_search_tb: self-checking bench for the nearest leader search
// Loads leader vectors, streams query vectors and compares every search result
// with an in-bench predictor of the squared distance search. A directed table
// comes first, then randomized phases over several register settings, with
// random idling on both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------

module nearest_leader_search_tb;

    import nls_pkg::*;

    // One search result as the bench sees it.
    typedef struct {
        logic [LEAD_FIELD_W-1:0] index;
        logic [DIST_W-1:0]       distance;
        logic                    none;
    } nearest_t;

    // A directed row either writes a register or sends one item.
    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        int                     reg_value;
        nls_op_t                op;
        int                     lead;
        int                     dim;
        int                     value;
        bit                     last;
        bit                     typed;     // outcome below is used instead of the predictor
        nearest_t               outcome;
    } stim_row_t;

    // Register setting and item budget of one random phase.
    typedef struct {
        int leaders;
        int dims;
        int budget;
    } phase_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // leader_index, dim_index, element_value
    logic                 s_tlast;   // last_element
    logic                 s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // nearest_index, nearest_distance
    logic                 m_tuser;   // no_leaders

    // Predictor copy of the block state and registers.
    logic signed [ELEM_W-1:0] leader_table [MAX_LEADERS][MAX_DIMS];
    logic signed [ELEM_W-1:0] query_vec [MAX_DIMS];
    logic [LCOUNT_W-1:0]      leader_count_reg;
    logic [DCOUNT_W-1:0]      dims_reg;

    // Leader entries written so far; a search never reads one that is not.
    bit leader_loaded [MAX_LEADERS][MAX_DIMS];

    nearest_t nearest_expected_q[$];

    int mismatch_count     = 0;
    int items_sent         = 0;
    int sender_idle_pct    = 14;
    int receiver_stall_pct = 65;
    bit hold_off_req       = 1'b0;

    // Directed table. Typed outcomes are the ones that can be read off directly:
    // the empty table after reset, full-scale differences, a tie and zero dimensions.
    stim_row_t directed_steps [19] = '{
        // After reset no leader is in use, so the search reports that flag.
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   0,    0, 1'b1, 1'b1, '{0, 0, 1'b1}},
        '{ROW_REG,  REG_LEADER_COUNT, 1, OP_LEADER, 0,   0,    0, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_REG,  REG_DIMS_IN_USE,  1, OP_LEADER, 0,   0,    0, 1'b0, 1'b0, '{0, 0, 1'b0}},
        // Largest possible difference in both directions: 255 squared.
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_LEADER, 0,   0, -128, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   0,  127, 1'b1, 1'b1, '{0, 65025, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_LEADER, 0,   0,  127, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  63,  0, -128, 1'b1, 1'b1, '{0, 65025, 1'b0}},
        // The last flag on a leader write starts nothing; top slot and top dimension.
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_LEADER, 63, 127,  -1, 1'b1, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   0,  127, 1'b1, 1'b1, '{0, 0, 1'b0}},
        // Two leaders at the same distance: the lower index wins.
        '{ROW_REG,  REG_LEADER_COUNT, 2, OP_LEADER, 0,   0,    0, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_LEADER, 1,   0,  127, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   0,    0, 1'b1, 1'b1, '{0, 16129, 1'b0}},
        // Two dimensions, assembled over two query items.
        '{ROW_REG,  REG_DIMS_IN_USE,  2, OP_LEADER, 0,   0,    0, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_LEADER, 0,   1,   -5, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_LEADER, 1,   1,    9, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   1,   10, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   0,    1, 1'b1, 1'b0, '{0, 0, 1'b0}},
        // Zero dimensions: every distance is zero and leader zero wins.
        '{ROW_REG,  REG_DIMS_IN_USE,  0, OP_LEADER, 0,   0,    0, 1'b0, 1'b0, '{0, 0, 1'b0}},
        '{ROW_ITEM, REG_LEADER_COUNT, 0, OP_QUERY,  0,   5,    3, 1'b1, 1'b1, '{0, 0, 1'b0}}
    };

    // Random phases. Mostly small tables; full-width tables of 64 leaders,
    // one with the full 128 dimensions, and oversized register values that
    // must clamp to the store sizes.
    phase_t phases [11] = '{
        '{3,   4,   90},
        '{8,   2,   80},
        '{64,  2,  160},
        '{127, 1,   60},
        '{0,   7,   40},
        '{1,   255, 200},
        '{5,   3,   80},
        '{2,   16, 100},
        '{16,  1,   50},
        '{64,  0,   30},
        '{4,   6,   80}
    };

    nearest_leader_search DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock; rising edges at 5, 15, 25 ns and so on.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one accepted item to the predictor state. A final query element
    // runs the full search and returns 1 with the nearest leader in res.
    function automatic bit predict_nearest(input nls_op_t op,
                                           input logic [LEAD_FIELD_W-1:0] lead,
                                           input logic [DIM_FIELD_W-1:0] dim,
                                           input logic signed [ELEM_W-1:0] value,
                                           input logic last,
                                           output nearest_t res);
        int n_lead;
        int n_dim;
        int acc;
        int diff;
        int best;
        int best_idx;
        res = '{0, 0, 1'b0};
        if (op == OP_LEADER)
        begin
            leader_table[lead][dim] = value;
            return 1'b0;
        end
        // The final element is stored before the search reads the buffer.
        query_vec[dim] = value;
        if (!last)
            return 1'b0;
        // Register values beyond the store sizes clamp to them.
        n_lead = (leader_count_reg > MAX_LEADERS) ? MAX_LEADERS : int'(leader_count_reg);
        n_dim  = (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
        if (n_lead == 0)
        begin
            res.none = 1'b1;
            return 1'b1;
        end
        best = 0;
        best_idx = 0;
        for (int l = 0; l < n_lead; l++)
        begin
            acc = 0;
            for (int d = 0; d < n_dim; d++)
            begin
                diff = int'(query_vec[d]) - int'(leader_table[l][d]);
                acc += diff * diff;
            end
            // Only a strictly smaller distance replaces the best so far.
            if (l == 0 || acc < best)
            begin
                best = acc;
                best_idx = l;
            end
        end
        res.index    = best_idx[LEAD_FIELD_W-1:0];
        res.distance = (best > DIST_MAX) ? DIST_MAX : best[DIST_W-1:0];
        return 1'b1;
    endfunction

    // Element values lean on the extremes and on a narrow band around zero,
    // which makes equal distances, and so ties, common.
    function automatic int pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return ($urandom_range(1) != 0) ? 127 : -128;
        if (r < 40)
            return int'($urandom_range(2)) - 1;
        return int'($urandom_range(255)) - 128;
    endfunction

    // Offers one item, starting at a falling edge, after a random idle stretch.
    // The valid line is left high on return so that back-to-back items keep it
    // asserted without a glitch; whoever goes idle next lowers it.
    task automatic send_item(input nls_op_t op, input int lead, input int dim,
                             input int value, input bit last,
                             input bit typed, input nearest_t typed_res);
        nearest_t res;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'b000, 8'(value), 7'(dim), 6'(lead)};
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_nearest(op, 6'(lead), 7'(dim), 8'(value), last, res))
            nearest_expected_q.insert(nearest_expected_q.size(), typed ? typed_res : res);
        if (op == OP_LEADER)
            leader_loaded[lead][dim] = 1'b1;
        items_sent++;
        // Idling profile: sender light and receiver heavy, then swapped, then none.
        if (items_sent == 360)
        begin
            sender_idle_pct    = 65;
            receiver_stall_pct = 14;
        end
        else if (items_sent == 720)
        begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
        end
        @(negedge clk);
    endtask

    // Brings the block to rest: no item offered, every expected result
    // delivered, and then a wait for an item that causes no result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (nearest_expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // One register write, then a pause with the enable low so that consecutive
    // writes never raise and lower the enable in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 8'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LEADER_COUNT)
            leader_count_reg = 7'(value);
        else
            dims_reg = 8'(value);
        @(negedge clk);
    endtask

    // Stimulus: reset, the directed table, then the random phases.
    initial
    begin
        int       n_lead;
        int       n_dim;
        int       phase_start;
        int       rot;
        int       r;
        int       lead;
        int       dim;
        bit       extra;
        bit       broken;
        nearest_t blank;

        blank     = '{0, 0, 1'b0};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LEADER_COUNT;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = OP_LEADER;
        leader_count_reg = '0;
        dims_reg         = 8'd100;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end
            else
            begin
                send_item(directed_steps[i].op, directed_steps[i].lead, directed_steps[i].dim,
                          directed_steps[i].value, directed_steps[i].last,
                          directed_steps[i].typed, directed_steps[i].outcome);
            end
        end

        foreach (phases[p])
        begin
            drain_results();
            write_reg(REG_LEADER_COUNT, phases[p].leaders);
            write_reg(REG_DIMS_IN_USE, phases[p].dims);
            n_lead = (phases[p].leaders > MAX_LEADERS) ? MAX_LEADERS : phases[p].leaders;
            n_dim  = (phases[p].dims > MAX_DIMS) ? MAX_DIMS : phases[p].dims;
            phase_start = items_sent;

            // Every leader entry that this setting searches gets a value first.
            for (int l = 0; l < n_lead; l++)
                for (int d = 0; d < n_dim; d++)
                    if (!leader_loaded[l][d])
                        send_item(OP_LEADER, l, d, pick_value(), 1'($urandom_range(1)),
                                  1'b0, blank);

            // Long hold-off on the result side while queries keep coming, so
            // the output register fills and the next search stalls the input.
            if (p == 6)
                hold_off_req = 1'b1;

            while (items_sent - phase_start < phases[p].budget)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    // A whole query vector in rotated dimension order, now and
                    // then with leader rewrites mixed in. Some end on an extra
                    // element at any dimension, and a few break off unfinished.
                    rot    = (n_dim > 0) ? $urandom_range(n_dim - 1) : 0;
                    extra  = (n_dim == 0) || ($urandom_range(99) < 15);
                    broken = ($urandom_range(99) < 8);
                    for (int k = 0; k < n_dim; k++)
                    begin
                        if ($urandom_range(99) < 10)
                            send_item(OP_LEADER, $urandom_range(63), $urandom_range(127),
                                      pick_value(), 1'($urandom_range(1)), 1'b0, blank);
                        send_item(OP_QUERY, $urandom_range(63), (k + rot) % n_dim, pick_value(),
                                  !broken && !extra && (k == n_dim - 1), 1'b0, blank);
                    end
                    if (extra)
                        send_item(OP_QUERY, $urandom_range(63), $urandom_range(127),
                                  pick_value(), !broken, 1'b0, blank);
                end
                else if (r < 90)
                begin
                    // Leader rewrite, half the time inside the searched region.
                    lead = (n_lead > 0 && $urandom_range(1) != 0) ?
                           $urandom_range(n_lead - 1) : $urandom_range(63);
                    dim  = (n_dim > 0 && $urandom_range(1) != 0) ?
                           $urandom_range(n_dim - 1) : $urandom_range(127);
                    send_item(OP_LEADER, lead, dim, pick_value(), 1'($urandom_range(1)),
                              1'b0, blank);
                end
                else
                begin
                    // Stray query element that only overwrites the buffer.
                    send_item(OP_QUERY, $urandom_range(63), $urandom_range(127),
                              pick_value(), 1'b0, 1'b0, blank);
                end
            end
        end

        drain_results();
        repeat (30) @(negedge clk);
        if (mismatch_count == 0)
            $display("nearest_leader_search_tb: PASS");
        else
            $display("nearest_leader_search_tb: FAIL");
        $finish;
    end

    // Result side: random stalls by the current profile, plus one long hold-off
    // counted here when the stimulus asks for it.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        nearest_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (nearest_expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: index %0d distance %0d no_leaders %0b",
                         $time, m_tdata[5:0], m_tdata[28:6], m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = nearest_expected_q.pop_front();
                if (m_tdata[5:0] !== want.index || m_tdata[28:6] !== want.distance
                    || m_tuser !== want.none)
                begin
                    $display("%0t: result mismatch: expected index %0d distance %0d no_leaders %0b",
                             $time, want.index, want.distance, want.none);
                    $display("%0t:                  actual index %0d distance %0d no_leaders %0b",
                             $time, m_tdata[5:0], m_tdata[28:6], m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("nearest_leader_search_tb: FAIL");
        $finish;
    end

endmodule
